>>> design/ebd_pkg.sv
// ----------------------------------------------------------------------------
// ebd_pkg
// Shared constants and helpers for the Euler basis projection block.
// ----------------------------------------------------------------------------
`default_nettype none
package ebd_pkg;

	localparam int CORDIC_STEPS = 30;
	localparam int CW = 34;	// CORDIC x/y/z datapath width

	localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

	function automatic logic signed [CW-1:0] atan_lut(input int i);
		logic signed [CW-1:0] r;
		begin
			case (i)
				0: r = 34'sh20000000;  1: r = 34'sh12E4051E;  2: r = 34'sh09FB385B;
				3: r = 34'sh051111D4;  4: r = 34'sh028B0D43;  5: r = 34'sh0145D7E1;
				6: r = 34'sh00A2F61E;  7: r = 34'sh00517C55;  8: r = 34'sh0028BE53;
				9: r = 34'sh00145F2F; 10: r = 34'sh000A2F98; 11: r = 34'sh000517CC;
				12: r = 34'sh00028BE6; 13: r = 34'sh000145F3; 14: r = 34'sh0000A2FA;
				15: r = 34'sh0000517D; 16: r = 34'sh000028BE; 17: r = 34'sh0000145F;
				18: r = 34'sh00000A30; 19: r = 34'sh00000518; 20: r = 34'sh0000028C;
				21: r = 34'sh00000146; 22: r = 34'sh000000A3; 23: r = 34'sh00000051;
				24: r = 34'sh00000029; 25: r = 34'sh00000014; 26: r = 34'sh0000000A;
				27: r = 34'sh00000005; 28: r = 34'sh00000003; 29: r = 34'sh00000001;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

	// Round a Q2.30-scale product to Q1.15 and saturate to 16 bits.
	function automatic logic signed [15:0] rnd_sat16(input logic signed [47:0] t);
		logic signed [47:0] r;
		begin
			r = (t + 48'sd16384) >>> 15;
			if (r > 48'sd32767) return 16'sd32767;
			else if (r < -48'sd32768) return -16'sd32768;
			else return r[15:0];
		end
	endfunction

	// Round only, keeping 17 bits (intermediate terms never exceed that).
	function automatic logic signed [16:0] rnd17(input logic signed [47:0] t);
		logic signed [47:0] r;
		begin
			r = (t + 48'sd16384) >>> 15;
			return r[16:0];
		end
	endfunction

endpackage
`default_nettype wire

>>> design/euler_basis_decompose.sv
// ----------------------------------------------------------------------------
// euler_basis_decompose
// Pipelined CORDIC sine/cosine, basis vector build and point projection.
// ----------------------------------------------------------------------------
// Channel   Dir  Content
// s_axis    in   tdata: point_x, point_y, point_z, angle_x, angle_y, angle_z
// m_axis    out  tdata: fwd_x..z, right_x..z, up_x..z, coef_fwd, coef_right, coef_up
//
// One beat per cycle while m_axis is not stalled; a beat passes the input load, the
// thirty CORDIC stages, then the quadrant, product, basis and dot product stages.
// arst_n clears all valid bits; payload registers are not reset.
// A stall on m_axis freezes the whole pipeline; s_axis_tready follows the
// output register being empty or drained, so no beat is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none
module euler_basis_decompose
	import ebd_pkg::*;
#(
	parameter int ANGLE_BITS = 16,
	parameter int COORD_BITS = 24
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic      s_axis_tready,
	// point_x, point_y, point_z, angle_x, angle_y, angle_z (low bit first)
	input  wire logic [((3*COORD_BITS+3*ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic      m_axis_tvalid,
	input  wire logic m_axis_tready,
	// fwd_x,y,z, right_x,y,z, up_x,y,z, coef_fwd, coef_right, coef_up (low bit first)
	output logic [((144+3*(COORD_BITS+1)+7)/8)*8-1:0] m_axis_tdata
);

	localparam int CB = COORD_BITS;
	localparam int AB = ANGLE_BITS;
	localparam int NST = CORDIC_STEPS + 6;
	localparam int OW = ((144+3*(CB+1)+7)/8)*8;

	typedef logic signed [CW-1:0] cw_t;

	// Global stall: advance when output is free
	logic adv;
	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	logic [NST-1:0] vld_q;

	// CORDIC pipeline storage, the stage 0 load plus one entry per step (3 angles)
	cw_t cx_s [0:CORDIC_STEPS][3];
	cw_t cy_s [0:CORDIC_STEPS][3];
	cw_t cz_s [0:CORDIC_STEPS][3];
	logic [1:0] quad_s [0:CORDIC_STEPS][3];
	logic signed [CB-1:0] pt_s [0:CORDIC_STEPS+3][3];

	// Stage 0 load
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 3; a++) begin
				logic [31:0] ph;
				ph = {s_axis_tdata[3*CB + a*AB +: AB], {(32-AB){1'b0}}};
				quad_s[0][a] <= ph[31:30];
				cz_s[0][a] <= cw_t'({2'b00, ph[29:0]});
				cx_s[0][a] <= CORDIC_X0;
				cy_s[0][a] <= '0;
				pt_s[0][a] <= s_axis_tdata[a*CB +: CB];
			end
		end
	end

	// CORDIC micro-rotation stages
	genvar gi;
	generate
		for (gi = 0; gi < CORDIC_STEPS; gi++) begin : g_cordic
			always_ff @(posedge clk) begin
				if (adv) begin
					for (int a = 0; a < 3; a++) begin
						if (!cz_s[gi][a][CW-1]) begin
							cx_s[gi+1][a] <= cx_s[gi][a] - (cy_s[gi][a] >>> gi);
							cy_s[gi+1][a] <= cy_s[gi][a] + (cx_s[gi][a] >>> gi);
							cz_s[gi+1][a] <= cz_s[gi][a] - atan_lut(gi);
						end else begin
							cx_s[gi+1][a] <= cx_s[gi][a] + (cy_s[gi][a] >>> gi);
							cy_s[gi+1][a] <= cy_s[gi][a] - (cx_s[gi][a] >>> gi);
							cz_s[gi+1][a] <= cz_s[gi][a] + atan_lut(gi);
						end
						quad_s[gi+1][a] <= quad_s[gi][a];
						pt_s[gi+1][a] <= pt_s[gi][a];
					end
				end
			end
		end
	endgenerate

	// Round and map by quadrant
	logic signed [15:0] c_s1 [3];
	logic signed [15:0] s_s1 [3];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 3; a++) begin
				logic signed [15:0] xc, ys;
				xc = rnd_sat16(48'(cx_s[CORDIC_STEPS][a]));
				ys = rnd_sat16(48'(cy_s[CORDIC_STEPS][a]));
				case (quad_s[CORDIC_STEPS][a])
					2'd0: begin c_s1[a] <= xc; s_s1[a] <= ys; end
					2'd1: begin c_s1[a] <= -ys; s_s1[a] <= xc; end
					2'd2: begin c_s1[a] <= -xc; s_s1[a] <= -ys; end
					default: begin c_s1[a] <= ys; s_s1[a] <= -xc; end
				endcase
			end
			pt_s[CORDIC_STEPS+1] <= pt_s[CORDIC_STEPS];
		end
	end

	// First products
	logic signed [15:0] sy_s2, cx_s2, sz_s2;
	logic signed [16:0] czsx_s2, sxsz_s2, cxcz_s2, cxsy_s2;
	logic signed [15:0] v0_s2, v1_s2, v5_s2, v8_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			czsx_s2 <= rnd17(48'(c_s1[2] * s_s1[0]));
			sxsz_s2 <= rnd17(48'(s_s1[0] * s_s1[2]));
			cxcz_s2 <= rnd17(48'(c_s1[0] * c_s1[2]));
			cxsy_s2 <= rnd17(48'(c_s1[0] * s_s1[1]));
			v0_s2 <= rnd_sat16(48'(c_s1[1] * c_s1[2]));
			v1_s2 <= rnd_sat16(-48'(c_s1[1] * s_s1[2]));
			v5_s2 <= rnd_sat16(-48'(c_s1[1] * s_s1[0]));
			v8_s2 <= rnd_sat16(48'(c_s1[0] * c_s1[1]));
			sy_s2 <= s_s1[1];
			cx_s2 <= c_s1[0];
			sz_s2 <= s_s1[2];
			pt_s[CORDIC_STEPS+2] <= pt_s[CORDIC_STEPS+1];
		end
	end
	// cx*cz full product kept for right_y
	logic signed [31:0] cxczf_s2;
	always_ff @(posedge clk) begin
		if (adv) cxczf_s2 <= c_s1[0] * c_s1[2];
	end

	// Second products
	logic signed [15:0] v_s3 [9];
	always_ff @(posedge clk) begin
		if (adv) begin
			v_s3[0] <= v0_s2;
			v_s3[1] <= v1_s2;
			v_s3[2] <= sy_s2;
			v_s3[3] <= rnd_sat16(48'(czsx_s2 * sy_s2) + 48'(cx_s2 * sz_s2));
			v_s3[4] <= rnd_sat16(48'(cxczf_s2) - 48'(sxsz_s2 * sy_s2));
			v_s3[5] <= v5_s2;
			v_s3[6] <= rnd_sat16((48'(sxsz_s2) <<< 15) - 48'(cxcz_s2 * sy_s2));
			v_s3[7] <= rnd_sat16((48'(czsx_s2) <<< 15) + 48'(cxsy_s2 * sz_s2));
			v_s3[8] <= v8_s2;
			pt_s[CORDIC_STEPS+3] <= pt_s[CORDIC_STEPS+2];
		end
	end

	// Point by component products
	localparam int PW = CB + 16;
	logic signed [PW-1:0] pr_s4 [9];
	logic signed [15:0] v_s4 [9];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 9; k++) begin
				pr_s4[k] <= PW'(pt_s[CORDIC_STEPS+3][k%3] * v_s3[k]);
				v_s4[k] <= v_s3[k];
			end
		end
	end

	// Sum, round, saturate into output register
	localparam int SW = PW + 2;
	localparam logic signed [SW-1:0] CMAX = SW'({CB{1'b1}});
	localparam logic signed [SW-1:0] CMIN = ~CMAX;
	logic [OW-1:0] out_q;
	always_ff @(posedge clk) begin
		if (adv) begin
			logic [OW-1:0] o;
			o = '0;
			for (int k = 0; k < 9; k++) o[16*k +: 16] = v_s4[k];
			for (int k = 0; k < 3; k++) begin
				logic signed [SW-1:0] d, r;
				d = SW'(pr_s4[3*k]) + SW'(pr_s4[3*k+1]) + SW'(pr_s4[3*k+2]);
				r = (d + SW'(16384)) >>> 15;
				if (r > CMAX)
					o[144 + k*(CB+1) +: CB+1] = CMAX[CB:0];
				else if (r < CMIN)
					o[144 + k*(CB+1) +: CB+1] = CMIN[CB:0];
				else
					o[144 + k*(CB+1) +: CB+1] = r[CB:0];
			end
			out_q <= o;
		end
	end
	assign m_axis_tdata = out_q;

	// Valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], s_axis_tvalid};
		end
	end
	assign m_axis_tvalid = vld_q[NST-1];

endmodule
`default_nettype wire

>>> tb/sv/euler_basis_decompose_tb.sv
// ----------------------------------------------------------------------------
// euler_basis_decompose_tb
// Drives points and Euler angles into the basis projection block, predicts
// the basis vectors and dot products from its own CORDIC and product terms,
// and checks every result beat field by field under random idling and a long
// output stall.
// ----------------------------------------------------------------------------
`default_nettype none
module euler_basis_decompose_tb;

	localparam int AB = 16;
	localparam int CB = 24;
	localparam int IW = ((3*CB+3*AB+7)/8)*8;
	localparam int OW = ((144+3*(CB+1)+7)/8)*8;
	localparam int LAT = 36;
	localparam int N_RANDOM = 400;

	typedef struct packed {
		logic [AB-1:0] az, ay, ax;
		logic [CB-1:0] pz, py, px;
	} pose_t;

	typedef struct packed {
		logic [CB:0] cu, cr, cf;
		logic [15:0] uz, uy, ux, rz, ry, rx, fz, fy, fx;
	} basis_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IW-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OW-1:0] m_axis_tdata;

	euler_basis_decompose #(.ANGLE_BITS(AB), .COORD_BITS(CB)) DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	basis_t expected_basis[$];
	int n_err = 0;
	int n_sent = 0;
	int n_got = 0;
	bit stall_hold = 0;
	bit no_idle = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("euler_basis_decompose: mismatch");
		$finish;
	end

	function automatic longint rshift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint q15_round(longint t);
		return rshift(t + 16384, 15);
	endfunction

	// Quadrant-folded CORDIC sine/cosine of a binary angle, in Q1.15
	function automatic void angle_sincos(logic [AB-1:0] ang, output longint c,
			output longint s);
		logic [31:0] phase;
		longint x, y, z, dx, dy, xc, ys;
		longint arc[30] = '{
			'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
			'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
			'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
			'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
			'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001};
		phase = {ang, {(32-AB){1'b0}}};
		x = 652032874;
		y = 0;
		z = phase[29:0];
		for (int i = 0; i < 30; i++) begin
			dx = rshift(y, i);
			dy = rshift(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= arc[i];
			end else begin
				x += dx; y -= dy; z += arc[i];
			end
		end
		xc = clip(q15_round(x), -32768, 32767);
		ys = clip(q15_round(y), -32768, 32767);
		case (phase[31:30])
			2'd0: begin c = xc; s = ys; end
			2'd1: begin c = -ys; s = xc; end
			2'd2: begin c = -xc; s = -ys; end
			default: begin c = ys; s = -xc; end
		endcase
	endfunction

	// Build the basis vectors of one pose and project its point onto them
	function automatic basis_t project_pose(pose_t p);
		longint cx, sx, cy, sy, cz, sz, czsx, sxsz, cxcz, cxsy, d;
		longint v[9];
		longint pt[3];
		longint cmax;
		basis_t b;
		angle_sincos(p.ax, cx, sx);
		angle_sincos(p.ay, cy, sy);
		angle_sincos(p.az, cz, sz);
		czsx = q15_round(cz * sx);
		sxsz = q15_round(sx * sz);
		cxcz = q15_round(cx * cz);
		cxsy = q15_round(cx * sy);
		v[0] = q15_round(cy * cz);
		v[1] = q15_round(-(cy * sz));
		v[2] = sy;
		v[3] = q15_round(czsx * sy + cx * sz);
		v[4] = q15_round(cx * cz - sxsz * sy);
		v[5] = q15_round(-(cy * sx));
		v[6] = q15_round(sxsz * 32768 - cxcz * sy);
		v[7] = q15_round(czsx * 32768 + cxsy * sz);
		v[8] = q15_round(cx * cy);
		foreach (v[k]) v[k] = clip(v[k], -32768, 32767);
		pt[0] = longint'($signed(p.px));
		pt[1] = longint'($signed(p.py));
		pt[2] = longint'($signed(p.pz));
		b.fx = 16'(v[0]); b.fy = 16'(v[1]); b.fz = 16'(v[2]);
		b.rx = 16'(v[3]); b.ry = 16'(v[4]); b.rz = 16'(v[5]);
		b.ux = 16'(v[6]); b.uy = 16'(v[7]); b.uz = 16'(v[8]);
		cmax = (longint'(1) << CB) - 1;
		for (int k = 0; k < 3; k++) begin
			d = pt[0] * v[3*k] + pt[1] * v[3*k+1] + pt[2] * v[3*k+2];
			d = clip(q15_round(d), -cmax - 1, cmax);
			if (k == 0) b.cf = (CB+1)'(d);
			else if (k == 1) b.cr = (CB+1)'(d);
			else b.cu = (CB+1)'(d);
		end
		return b;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		n_err++;
		$display("ERROR beat %0d: %s got %0h expected %0h", n_got, what, got, want);
	endtask

	// Directed table: angle extremes, quadrant edges, point extremes
	localparam int N_DIR = 14;
	pose_t dir_pose[N_DIR];
	bit dir_known[N_DIR];
	basis_t dir_result[N_DIR];

	initial begin
		for (int i = 0; i < N_DIR; i++) dir_known[i] = 0;
		dir_pose[0] = '{ax: 0, ay: 0, az: 0, px: 24'h000100, py: 0, pz: 0};
		// zero angles: cosines clip to +32767, so the product terms round to 32766
		dir_known[0] = 1;
		dir_result[0] = '{fx: 16'sd32766, fy: 0, fz: 0, rx: 0, ry: 16'sd32766, rz: 0,
			ux: 0, uy: 0, uz: 16'sd32766, cf: 25'd256, cr: 0, cu: 0};
		dir_pose[1] = '{ax: 16'h4000, ay: 16'h4000, az: 16'h4000,
			px: 24'h7FFFFF, py: 24'h7FFFFF, pz: 24'h7FFFFF};
		dir_pose[2] = '{ax: 16'h8000, ay: 16'h8000, az: 16'h8000,
			px: 24'h800000, py: 24'h800000, pz: 24'h800000};
		dir_pose[3] = '{ax: 16'hC000, ay: 16'hC000, az: 16'hC000,
			px: 24'h7FFFFF, py: 24'h800000, pz: 24'h7FFFFF};
		dir_pose[4] = '{ax: 16'hFFFF, ay: 16'hFFFF, az: 16'hFFFF,
			px: 24'hFFFFFF, py: 24'h000001, pz: 24'h800000};
		dir_pose[5] = '{ax: 16'h0001, ay: 16'h3FFF, az: 16'h4001,
			px: 24'h555555, py: 24'hAAAAAA, pz: 24'h123456};
		dir_pose[6] = '{ax: 16'h2000, ay: 16'h6000, az: 16'hA000,
			px: 24'h7FFFFF, py: 24'h7FFFFF, pz: 24'h7FFFFF};
		dir_pose[7] = '{ax: 16'h7FFF, ay: 16'h8001, az: 16'hBFFF,
			px: 24'h800000, py: 24'h7FFFFF, pz: 24'h800000};
		dir_pose[8] = '{ax: 16'hE000, ay: 16'h2000, az: 16'h6000,
			px: 24'h800000, py: 24'h800000, pz: 24'h800000};
		dir_pose[9] = '{ax: 16'hAAAA, ay: 16'h5555, az: 16'hFFFF,
			px: 0, py: 0, pz: 0};
		dir_pose[10] = '{ax: 16'h4000, ay: 0, az: 0, px: 0, py: 24'h7FFFFF, pz: 0};
		dir_pose[11] = '{ax: 0, ay: 16'h4000, az: 0, px: 0, py: 0, pz: 24'h800000};
		dir_pose[12] = '{ax: 0, ay: 0, az: 16'h4000, px: 24'hFFFF00, py: 0, pz: 0};
		dir_pose[13] = '{ax: 16'h5555, ay: 16'hAAAA, az: 16'h1234,
			px: 24'h7FFFFF, py: 24'h800000, pz: 24'h000000};
	end

	function automatic pose_t random_pose();
		pose_t p;
		p.ax = AB'($urandom);
		p.ay = AB'($urandom);
		p.az = AB'($urandom);
		case ($urandom_range(0, 3))
			0: begin
				p.px = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
				p.py = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
				p.pz = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
			end
			1: begin
				p.px = CB'($signed(10'($urandom)));
				p.py = CB'($signed(10'($urandom)));
				p.pz = CB'($signed(10'($urandom)));
			end
			default: begin
				p.px = CB'($urandom); p.py = CB'($urandom); p.pz = CB'($urandom);
			end
		endcase
		// quadrant edges now and then
		if ($urandom_range(0, 7) == 0) p.ay = {2'($urandom_range(0, 3)), 14'h0};
		return p;
	endfunction

	task automatic send_pose(pose_t p, bit known, basis_t want);
		// random idle gap before offering the beat
		while (!no_idle && $urandom_range(0, 99) < 21) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IW'(p);
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (known) expected_basis.push_back(want);
		else expected_basis.push_back(project_pose(p));
		n_sent++;
	endtask

	// Stimulus
	initial begin
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		arst_n = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < N_DIR; i++) send_pose(dir_pose[i], dir_known[i], dir_result[i]);
		for (int i = 0; i < N_RANDOM; i++) begin
			no_idle = (i >= 150 && i < 230);
			send_pose(random_pose(), 0, '0);
		end
		s_axis_tvalid <= 1'b0;
		while (expected_basis.size() != 0) @(posedge clk);
		repeat (LAT + 4) @(posedge clk);
		$display("Covered %0d poses: axis quadrant edges, coordinate extremes, random angles,",
			n_sent);
		$display("random idling both sides, a long output stall, %0d results checked.", n_got);
		if (n_err == 0) begin
			$display("euler_basis_decompose: match");
		end else begin
			$display("euler_basis_decompose: mismatch");
		end
		$finish;
	end

	// Long output hold-off so the pipeline fills and backs up the input
	initial begin
		wait (n_sent == 100);
		stall_hold = 1;
		repeat (200) @(posedge clk);
		stall_hold = 0;
	end

	// Receiver ready with random stalls
	initial begin
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			m_axis_tready <= !stall_hold && (no_idle || $urandom_range(0, 99) >= 21);
		end
	end

	// Check each accepted result beat against the oldest prediction
	always @(posedge clk) begin
		basis_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[$bits(basis_t)-1:0];
			n_got++;
			if (expected_basis.size() == 0) begin
				report_mismatch("unexpected beat", got.cf, 0);
			end else begin
				want = expected_basis.pop_front();
				if (got.fx !== want.fx) report_mismatch("fwd_x", got.fx, want.fx);
				if (got.fy !== want.fy) report_mismatch("fwd_y", got.fy, want.fy);
				if (got.fz !== want.fz) report_mismatch("fwd_z", got.fz, want.fz);
				if (got.rx !== want.rx) report_mismatch("right_x", got.rx, want.rx);
				if (got.ry !== want.ry) report_mismatch("right_y", got.ry, want.ry);
				if (got.rz !== want.rz) report_mismatch("right_z", got.rz, want.rz);
				if (got.ux !== want.ux) report_mismatch("up_x", got.ux, want.ux);
				if (got.uy !== want.uy) report_mismatch("up_y", got.uy, want.uy);
				if (got.uz !== want.uz) report_mismatch("up_z", got.uz, want.uz);
				if (got.cf !== want.cf) report_mismatch("coef_fwd", got.cf, want.cf);
				if (got.cr !== want.cr) report_mismatch("coef_right", got.cr, want.cr);
				if (got.cu !== want.cu) report_mismatch("coef_up", got.cu, want.cu);
			end
		end
	end

endmodule
`default_nettype wire
